// ----- sv/ssd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types and constants of the sorted set difference block.
// ----------------------------------------------------------------------------
package ssd_pkg;

   localparam int LIST_DEPTH   = 32;
   localparam int ID_BITS      = 16;
   localparam int ADDR_BITS    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_BITS     = $clog2(LIST_DEPTH + 1);
   localparam int FIELD_ID_BITS = 16;
   localparam int TOTAL_BITS   = 7;
   localparam int REMOVAL_BITS = 6;
   localparam int CODE_BITS    = 2;

   localparam logic [CODE_BITS-1:0] CMD_LOAD_OLD = 2'd0;
   localparam logic [CODE_BITS-1:0] CMD_LOAD_NEW = 2'd1;
   localparam logic [CODE_BITS-1:0] CMD_RUN      = 2'd2;

   localparam logic [CODE_BITS-1:0] KIND_ADD     = 2'd0;
   localparam logic [CODE_BITS-1:0] KIND_REMOVE  = 2'd1;
   localparam logic [CODE_BITS-1:0] KIND_NONE    = 2'd2;
   localparam logic [CODE_BITS-1:0] KIND_UNUSED  = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [CODE_BITS-1:0]     kind;
      logic [FIELD_ID_BITS-1:0] diff_id;
      logic [TOTAL_BITS-1:0]    total_count;
      logic [REMOVAL_BITS-1:0]  removal_count;
      logic                     overflow;
      logic                     last;
   } result_type;

endpackage

// ----- sv/ssd_list_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_list_ram
// Single-port-write, single-port-read list memory with registered read data.
// ----------------------------------------------------------------------------
module ssd_list_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/sorted_set_difference.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_difference
// Loads an old and a new ascending identifier list into two memories and,
// on a run request, walks both in merge order, reporting additions and
// removals with running counts.
//
//   Channel  Direction  tuser            tdata                        tlast
//   req_     in         cmd              item_id                      -
//   rsp_     out        kind             diff_id, counts, overflow    last
//
// A load request is taken only while the block is idle.
// Each merge step of a run passes through a memory read state, then a compare
// state; the run ends with a read that finds both lists exhausted and a done
// state that delivers the final result; the last result is held back one step
// so that it can be marked.
// Reset clears the state, list lengths, the overflow flag and the valid flags.
// A stalled result channel holds the walk; loads are taken even while the
// final result of a run still waits.
// ----------------------------------------------------------------------------
module sorted_set_difference
   import ssd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   input  logic [15:0] req_tdata,   // item_id[15:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   output logic [31:0] rsp_tdata,   // diff_id[15:0], total_count[22:16],
                                    // removal_count[28:23], overflow[29], zero
   output logic        rsp_tlast
);

   state_type               state_ff, state_in;
   logic [CNT_BITS-1:0]     old_len_ff, old_len_in;
   logic [CNT_BITS-1:0]     new_len_ff, new_len_in;
   logic [CNT_BITS-1:0]     io_ff, io_in;
   logic [CNT_BITS-1:0]     in_ff, in_in;
   logic [TOTAL_BITS-1:0]   total_ff, total_in;
   logic [REMOVAL_BITS-1:0] rem_ff, rem_in;
   logic                    dropped_ff, dropped_in;
   result_type              hold_ff, hold_in;
   logic                    hold_valid_ff, hold_valid_in;
   result_type              rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    old_wr, new_wr;
   logic [ID_BITS-1:0]      old_rd, new_rd;
   logic                    req_fire, out_free, old_av, new_av;
   logic                    take_new, take_old, emit;
   result_type              fresh;

   ssd_list_ram #(.DEPTH(LIST_DEPTH), .WIDTH(ID_BITS)) u_old_ram (
      .clock   (clock),
      .wr_en   (old_wr),
      .wr_addr (old_len_ff[ADDR_BITS-1:0]),
      .wr_data (req_tdata[ID_BITS-1:0]),
      .rd_addr (io_ff[ADDR_BITS-1:0]),
      .rd_data (old_rd)
   );

   ssd_list_ram #(.DEPTH(LIST_DEPTH), .WIDTH(ID_BITS)) u_new_ram (
      .clock   (clock),
      .wr_en   (new_wr),
      .wr_addr (new_len_ff[ADDR_BITS-1:0]),
      .wr_data (req_tdata[ID_BITS-1:0]),
      .rd_addr (in_ff[ADDR_BITS-1:0]),
      .rd_data (new_rd)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign old_av     = io_ff < old_len_ff;
   assign new_av     = in_ff < new_len_ff;

   assign old_wr = req_fire && (req_tuser == CMD_LOAD_OLD)
                   && (old_len_ff < CNT_BITS'(LIST_DEPTH));
   assign new_wr = req_fire && (req_tuser == CMD_LOAD_NEW)
                   && (new_len_ff < CNT_BITS'(LIST_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         old_len_ff    <= '0;
         new_len_ff    <= '0;
         dropped_ff    <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         old_len_ff    <= old_len_in;
         new_len_ff    <= new_len_in;
         dropped_ff    <= dropped_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      io_ff    <= io_in;
      in_ff    <= in_in;
      total_ff <= total_in;
      rem_ff   <= rem_in;
      hold_ff  <= hold_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      old_len_in    = old_len_ff;
      new_len_in    = new_len_ff;
      dropped_in    = dropped_ff;
      io_in         = io_ff;
      in_in         = in_ff;
      total_in      = total_ff;
      rem_in        = rem_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      take_new = 1'b0;
      take_old = 1'b0;
      if (old_av && new_av) begin
         take_new = new_rd < old_rd;
         take_old = old_rd < new_rd;
      end else begin
         take_new = new_av;
         take_old = !new_av;
      end
      emit = take_new || take_old;

      fresh.kind          = take_new ? KIND_ADD : KIND_REMOVE;
      fresh.diff_id       = FIELD_ID_BITS'(take_new ? new_rd : old_rd);
      fresh.total_count   = total_ff + TOTAL_BITS'(1);
      fresh.removal_count = rem_ff + REMOVAL_BITS'(take_old);
      fresh.overflow      = dropped_ff;
      fresh.last          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               priority if (req_tuser == CMD_LOAD_OLD) begin
                  if (old_wr) begin
                     old_len_in = old_len_ff + CNT_BITS'(1);
                  end else begin
                     dropped_in = 1'b1;
                  end
               end else if (req_tuser == CMD_LOAD_NEW) begin
                  if (new_wr) begin
                     new_len_in = new_len_ff + CNT_BITS'(1);
                  end else begin
                     dropped_in = 1'b1;
                  end
               end else if (req_tuser == CMD_RUN) begin
                  io_in         = '0;
                  in_in         = '0;
                  total_in      = '0;
                  rem_in        = '0;
                  hold_valid_in = 1'b0;
                  state_in      = ST_READ;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            if (old_av || new_av) begin
               state_in = ST_CMP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CMP: begin
            if (!emit) begin
               io_in    = io_ff + CNT_BITS'(1);
               in_in    = in_ff + CNT_BITS'(1);
               state_in = ST_READ;
            end else if (!hold_valid_ff || out_free) begin
               if (hold_valid_ff) begin
                  rsp_in       = hold_ff;
                  rsp_valid_in = 1'b1;
               end
               hold_in       = fresh;
               hold_valid_in = 1'b1;
               total_in      = fresh.total_count;
               rem_in        = fresh.removal_count;
               if (take_new) begin
                  in_in = in_ff + CNT_BITS'(1);
               end else begin
                  io_in = io_ff + CNT_BITS'(1);
               end
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               if (hold_valid_ff) begin
                  rsp_in      = hold_ff;
                  rsp_in.last = 1'b1;
               end else begin
                  rsp_in.kind          = KIND_NONE;
                  rsp_in.diff_id       = '0;
                  rsp_in.total_count   = '0;
                  rsp_in.removal_count = '0;
                  rsp_in.overflow      = dropped_ff;
                  rsp_in.last          = 1'b1;
               end
               rsp_valid_in  = 1'b1;
               hold_valid_in = 1'b0;
               old_len_in    = '0;
               new_len_in    = '0;
               dropped_in    = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {2'b00, rsp_ff.overflow, rsp_ff.removal_count,
                        rsp_ff.total_count, rsp_ff.diff_id};
   assign rsp_tlast  = rsp_ff.last;

endmodule

// ----- sv/ssd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks of the sorted set difference block, bound to its top.
// ----------------------------------------------------------------------------
module ssd_checker
   import ssd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [1:0]  rsp_tuser,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result request dropped while stalled");

   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == CMD_RUN) |=> !req_tready)
      else $error("block took a request right after a run request");

   a_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("block idle while a run is still incomplete");

   a_none_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_NONE)
      |-> rsp_tlast && (rsp_tdata[28:0] == 29'd0))
      else $error("malformed no-difference result");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != KIND_UNUSED)
      else $error("result with unused kind code");

endmodule

bind sorted_set_difference ssd_checker u_ssd_checker (.*);

// ----- sim/sorted_set_difference_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_difference_tb
// Self-checking bench for the sorted set difference block. Old and new
// identifier lists are loaded through the request channel and compared on
// run requests. A predictor inside the bench computes the additions,
// removals and running counts of every run. A checker compares each result
// field by field against the oldest predicted result. Directed tests come
// first: empty, equal, mixed, unsorted and full lists, then a long result
// stall. A random phase of mostly well-formed list pairs follows. The sender
// works in random bursts and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module sorted_set_difference_tb;
   import ssd_pkg::*;

   localparam logic [CODE_BITS-1:0] CMD_IGNORED = 2'd3;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 200;
   localparam int RANDOM_ITEMS = 30;

   typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [1:0]  rsp_tuser;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;

   logic [ID_BITS-1:0] old_ids [LIST_DEPTH];
   logic [ID_BITS-1:0] new_ids [LIST_DEPTH];
   int                 old_len = 0;
   int                 new_len = 0;
   logic               dropped = 1'b0;
   result_type         expected_diffs [$];
   result_type         head_diff;

   int          mismatches = 0;
   int          requests_counted = 0;
   int          runs_done = 0;
   int          results_checked = 0;
   int          burst_left = 0;
   int          idle_cycles = 0;
   int          long_hold_cycles = 0;
   int          hold_left = 0;
   int          mode_left = 0;
   int          rx_phase = 0;
   rx_mode_type rx_mode = RX_OPEN;

   sorted_set_difference DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // The last difference of a run is held back until the walk ends so that
   // it can be marked as last.
   task automatic predict_difference(input logic [1:0] cmd, input logic [15:0] id);
      int                      oi;
      int                      ni;
      logic [TOTAL_BITS-1:0]   total;
      logic [REMOVAL_BITS-1:0] removals;
      result_type              item;
      result_type              held;
      bit                      have_held;
      oi = 0;
      ni = 0;
      total = '0;
      removals = '0;
      have_held = 1'b0;
      if (cmd != CMD_IGNORED) begin
         requests_counted++;
      end
      case (cmd)
         CMD_LOAD_OLD: begin
            if (old_len < LIST_DEPTH) begin
               old_ids[old_len] = id;
               old_len++;
            end else begin
               dropped = 1'b1;
            end
         end
         CMD_LOAD_NEW: begin
            if (new_len < LIST_DEPTH) begin
               new_ids[new_len] = id;
               new_len++;
            end else begin
               dropped = 1'b1;
            end
         end
         CMD_RUN: begin
            while (oi < old_len || ni < new_len) begin
               if (oi < old_len && ni < new_len && old_ids[oi] == new_ids[ni]) begin
                  oi++;
                  ni++;
               end else begin
                  total++;
                  if (ni < new_len && (oi >= old_len || new_ids[ni] < old_ids[oi])) begin
                     item.kind = KIND_ADD;
                     item.diff_id = new_ids[ni];
                     ni++;
                  end else begin
                     removals++;
                     item.kind = KIND_REMOVE;
                     item.diff_id = old_ids[oi];
                     oi++;
                  end
                  item.total_count = total;
                  item.removal_count = removals;
                  item.overflow = dropped;
                  item.last = 1'b0;
                  if (have_held) begin
                     expected_diffs.push_back(held);
                  end
                  held = item;
                  have_held = 1'b1;
               end
            end
            if (!have_held) begin
               held.kind = KIND_NONE;
               held.diff_id = '0;
               held.total_count = '0;
               held.removal_count = '0;
               held.overflow = dropped;
            end
            held.last = 1'b1;
            expected_diffs.push_back(held);
            old_len = 0;
            new_len = 0;
            dropped = 1'b0;
            runs_done++;
         end
         default: begin
         end
      endcase
   endtask

   task automatic send_request(input logic [1:0] cmd, input logic [15:0] id);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= id;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_difference(cmd, id);
   endtask

   task automatic test_empty_lists();
      send_request(CMD_RUN, 16'hFFFF);
   endtask

   task automatic test_equal_lists();
      send_request(CMD_LOAD_OLD, 16'h0000);
      send_request(CMD_LOAD_NEW, 16'h0000);
      send_request(CMD_LOAD_OLD, 16'hFFFF);
      send_request(CMD_LOAD_NEW, 16'hFFFF);
      send_request(CMD_RUN, 16'h0000);
   endtask

   task automatic test_mixed_differences();
      send_request(CMD_LOAD_OLD, 16'd1);
      send_request(CMD_LOAD_NEW, 16'd0);
      send_request(CMD_LOAD_OLD, 16'd5);
      send_request(CMD_IGNORED, 16'h5A5A);
      send_request(CMD_LOAD_NEW, 16'd5);
      send_request(CMD_LOAD_OLD, 16'd9);
      send_request(CMD_LOAD_NEW, 16'hFFFF);
      send_request(CMD_RUN, 16'hA5A5);
   endtask

   task automatic test_unsorted_lists();
      send_request(CMD_LOAD_OLD, 16'd9);
      send_request(CMD_LOAD_OLD, 16'd3);
      send_request(CMD_LOAD_NEW, 16'd4);
      send_request(CMD_LOAD_NEW, 16'd4);
      send_request(CMD_RUN, 16'd0);
   endtask

   // Disjoint full lists give the largest counts; the extra loads overflow.
   task automatic test_full_lists();
      for (int i = 0; i <= LIST_DEPTH; i++) begin
         send_request(CMD_LOAD_OLD, 16'(2 * i));
         send_request(CMD_LOAD_NEW, 16'(2 * i + 1));
      end
      send_request(CMD_RUN, 16'd0);
      send_request(CMD_RUN, 16'd0);
   endtask

   task automatic test_back_pressure();
      for (int i = 0; i < 12; i++) begin
         send_request(CMD_LOAD_OLD, 16'(100 + 3 * i));
         send_request(CMD_LOAD_NEW, 16'(101 + 3 * i));
      end
      long_hold_cycles = HOLD_CYCLES;
      send_request(CMD_RUN, 16'd0);
      for (int i = 0; i < 6; i++) begin
         send_request(CMD_LOAD_NEW, 16'(40000 + i));
      end
      send_request(CMD_RUN, 16'd0);
   endtask

   task automatic test_random_sets();
      logic [15:0] old_q [$];
      logic [15:0] new_q [$];
      int          start_count;
      int          shape;
      int          span;
      int          id;
      int          count;
      start_count = requests_counted;
      while (requests_counted - start_count < RANDOM_ITEMS) begin
         old_q.delete();
         new_q.delete();
         shape = $urandom_range(0, 11);
         if (shape == 0) begin
            count = $urandom_range(0, 6);
            repeat (count) old_q.push_back(16'($urandom_range(0, 15)));
            count = $urandom_range(0, 6);
            repeat (count) new_q.push_back(16'($urandom_range(0, 15)));
         end else if (shape == 1) begin
            id = $urandom_range(0, 1000);
            count = LIST_DEPTH + $urandom_range(1, 3);
            repeat (count) begin
               old_q.push_back(16'(id));
               id += $urandom_range(1, 50);
            end
            new_q.push_back(16'($urandom_range(0, 16'hFFFF)));
         end else begin
            id = ($urandom_range(0, 3) == 0) ? $urandom_range(60000, 16'hFFFF)
                                             : $urandom_range(0, 100);
            span = ($urandom_range(0, 1) == 0) ? 3 : 3000;
            count = $urandom_range(0, 10);
            repeat (count) begin
               if (id <= 16'hFFFF) begin
                  case ($urandom_range(0, 3))
                     0, 1: begin
                        old_q.push_back(16'(id));
                        new_q.push_back(16'(id));
                     end
                     2: old_q.push_back(16'(id));
                     default: new_q.push_back(16'(id));
                  endcase
                  id += $urandom_range(0, span);
               end
            end
         end
         while (old_q.size() != 0 || new_q.size() != 0) begin
            if ($urandom_range(0, 11) == 0) begin
               send_request(CMD_IGNORED, 16'($urandom_range(0, 16'hFFFF)));
            end
            if (old_q.size() != 0 && (new_q.size() == 0 || $urandom_range(0, 1) == 0)) begin
               send_request(CMD_LOAD_OLD, old_q.pop_front());
            end else begin
               send_request(CMD_LOAD_NEW, new_q.pop_front());
            end
         end
         send_request(CMD_RUN, 16'($urandom_range(0, 16'hFFFF)));
      end
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_diffs.size() == 0) begin
            $error("result with none pending: kind %0d, diff_id %0d",
                   rsp_tuser, rsp_tdata[15:0]);
            mismatches++;
         end else begin
            head_diff = expected_diffs.pop_front();
            check_field("kind", head_diff.kind, rsp_tuser);
            check_field("diff_id", head_diff.diff_id, rsp_tdata[15:0]);
            check_field("total_count", head_diff.total_count, rsp_tdata[22:16]);
            check_field("removal_count", head_diff.removal_count, rsp_tdata[28:23]);
            check_field("overflow", head_diff.overflow, rsp_tdata[29]);
            check_field("padding", 0, rsp_tdata[31:30]);
            check_field("last", head_diff.last, rsp_tlast);
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_left == 0 && long_hold_cycles != 0) begin
         hold_left = long_hold_cycles;
         long_hold_cycles = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(16, 64);
         end
         mode_left--;
         rx_phase++;
         case (rx_mode)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
            default:   rsp_tready <= (rx_phase % 4 == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no request or result moved for %0d cycles.", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_empty_lists();
      test_equal_lists();
      test_mixed_differences();
      test_unsorted_lists();
      test_full_lists();
      test_back_pressure();
      test_random_sets();
      req_tvalid <= 1'b0;
      while (expected_diffs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests over %0d runs and checked %0d results.",
               requests_counted, runs_done, results_checked);
      $display("Lists were empty, equal, mixed, unsorted and full, with a long result stall.");
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
